FILE: design/rria_pkg.sv
package rria_pkg;

  // Identifier space and map geometry
  localparam int unsigned IdSpace = 256;
  localparam int unsigned IdW     = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned BitW    = $clog2(WordW);
  localparam int unsigned Rows    = IdSpace / WordW;
  localparam int unsigned RowW    = $clog2(Rows);
  localparam logic [IdW-1:0] IdMax = IdW'(IdSpace - 1);

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic {
    RegRangeLow  = 1'b0,
    RegRangeHigh = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic           operation;
    logic [IdW-1:0] target_id;
  } in_t;

  typedef struct packed {
    logic           success;
    logic [IdW-1:0] granted_id;
    logic           out_of_range;
  } out_t;

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StRead,
    StCheck,
    StDone
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic start;
    logic rd_en;
    logic next_row;
    logic next_phase;
    logic commit;
    logic set_fail;
    logic set_oor;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;
    logic in_range;
    logic range_empty;
    logic hit;
    logic last_row;
    logic phase1;
  } status_t;

endpackage

FILE: design/rria_ctrl.sv
module rria_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rria_pkg::status_t sts_i,
  output rria_pkg::cmd_t    cmd_o
);
  import rria_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDecide;
        end
      end
      StDecide: begin
        priority if (sts_i.is_free && !sts_i.in_range) begin
          cmd_o.set_oor = 1'b1;
          state_d       = StDone;
        end else if (!sts_i.is_free && sts_i.range_empty) begin
          cmd_o.set_fail = 1'b1;
          state_d        = StDone;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StCheck;
      end
      StCheck: begin
        priority if (sts_i.is_free || sts_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d      = StDone;
        end else if (!sts_i.last_row) begin
          cmd_o.next_row = 1'b1;
          state_d        = StRead;
        end else if (!sts_i.phase1) begin
          // wrap to the bottom of the range
          cmd_o.next_phase = 1'b1;
          state_d          = StRead;
        end else begin
          cmd_o.set_fail = 1'b1;
          state_d        = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == StIdle);

endmodule

FILE: design/rria_dp.sv
module rria_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rria_pkg::in_t               in_data_i,
  output rria_pkg::out_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [rria_pkg::IdW-1:0]    cfg_wdata_i,
  input  rria_pkg::cmd_t              cmd_i,
  output rria_pkg::status_t           sts_o
);
  import rria_pkg::*;

  logic [IdW-1:0]   low_q, high_q, cursor_q;
  logic [Rows-1:0]  row_vld_q;
  logic [WordW-1:0] mem_q [Rows];
  logic [WordW-1:0] rd_q;
  logic             op_q;
  logic [IdW-1:0]   tid_q;
  logic [RowW-1:0]  row_q;
  logic             phase_q;
  out_t             res_q, out_q;

  logic [IdW-1:0]   top, scan_lo, grant;
  logic [WordW-1:0] init_mask, scan_mask, eff, cand, wdata;
  logic [BitW-1:0]  bidx, bsel;
  logic             tid_in_range, hit;

  assign top          = (high_q > IdMax) ? IdMax : high_q;
  assign tid_in_range = (tid_q >= low_q) && (tid_q <= top);
  assign scan_lo      = phase_q ? low_q : cursor_q;

  // Row contents after a clear, and the window searched in this phase
  always_comb begin
    logic [IdW-1:0] id_v;
    init_mask = '0;
    scan_mask = '0;
    for (int b = 0; b < WordW; b++) begin
      id_v         = {row_q, BitW'(b)};
      init_mask[b] = (id_v >= low_q) && (id_v <= top);
      scan_mask[b] = (id_v >= scan_lo) && (id_v <= top);
    end
  end

  assign eff  = row_vld_q[row_q] ? rd_q : init_mask;
  assign cand = eff & scan_mask;
  assign hit  = |cand;

  // Lowest set bit wins
  always_comb begin
    bidx = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (cand[b]) begin
        bidx = BitW'(b);
      end
    end
  end

  assign bsel  = (op_q == OpFree) ? tid_q[BitW-1:0] : bidx;
  assign grant = {row_q, bidx};

  always_comb begin
    wdata       = eff;
    wdata[bsel] = (op_q == OpFree);
  end

  assign sts_o.is_free     = (op_q == OpFree);
  assign sts_o.in_range    = tid_in_range;
  assign sts_o.range_empty = (low_q > top);
  assign sts_o.hit         = hit;
  assign sts_o.last_row    = (row_q == top[IdW-1:BitW]);
  assign sts_o.phase1      = phase_q;

  // Map storage: one row read or written per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[row_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[row_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q     <= '0;
      high_q    <= IdMax;
      cursor_q  <= '0;
      row_vld_q <= '0;
    end else if (cfg_we_i) begin
      // any range write frees the whole map and parks the cursor at the bottom
      row_vld_q <= '0;
      unique case (reg_idx_e'(cfg_idx_i))
        RegRangeLow: begin
          low_q    <= cfg_wdata_i;
          cursor_q <= cfg_wdata_i;
        end
        RegRangeHigh: begin
          high_q   <= cfg_wdata_i;
          cursor_q <= low_q;
        end
        default: ;
      endcase
    end else if (cmd_i.commit) begin
      row_vld_q[row_q] <= 1'b1;
      if (op_q == OpAlloc) begin
        cursor_q <= (grant < top) ? grant + 1'b1 : low_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_data_i.operation;
      tid_q <= in_data_i.target_id;
    end
    if (cmd_i.start) begin
      row_q   <= (op_q == OpFree) ? tid_q[IdW-1:BitW] : cursor_q[IdW-1:BitW];
      phase_q <= 1'b0;
    end else if (cmd_i.next_row) begin
      row_q <= row_q + 1'b1;
    end else if (cmd_i.next_phase) begin
      row_q   <= low_q[IdW-1:BitW];
      phase_q <= 1'b1;
    end
    priority if (cmd_i.set_oor) begin
      res_q <= '{success: 1'b0, granted_id: '0, out_of_range: 1'b1};
    end else if (cmd_i.set_fail) begin
      res_q <= '{success: 1'b0, granted_id: '0, out_of_range: 1'b0};
    end else if (cmd_i.commit) begin
      if (op_q == OpFree) begin
        res_q <= '{success: !eff[bsel], granted_id: '0, out_of_range: 1'b0};
      end else begin
        res_q <= '{success: 1'b1, granted_id: grant, out_of_range: 1'b0};
      end
    end else begin
      res_q <= res_q;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: design/round_robin_id_allocator.sv
// A free reads and rewrites the 32-bit map row of its id, or skips the read if out of range;
// an allocate visits 32-bit map rows (one memory read and one check each) from the cursor
// up to the top of the range, then wraps to the bottom, at most across all 8 rows twice,
// and skips the search when the range is empty.
// One item in flight; the next beat is taken the cycle after the result is registered.
// Reset: range 0..255, every id free, cursor at 0; a range write frees the map at once.
module round_robin_id_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  rria_pkg::in_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rria_pkg::out_t           out_data_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [rria_pkg::IdW-1:0] cfg_wdata_i
);
  import rria_pkg::*;

  cmd_t    cmd;
  status_t sts;

  rria_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rria_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
